// ===== rtl/motion_vector_block_mask_assert.svh =====
// Assertion macros for the motion vector block mask
`ifndef MOTION_VECTOR_BLOCK_MASK_ASSERT_SVH
`define MOTION_VECTOR_BLOCK_MASK_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every edge out of reset
`define MVBM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition must never be seen out of reset
`define MVBM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MVBM_ASSERT(lbl, prop, msg)
`define MVBM_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/mvbm_pkg.sv =====
// Shared types and constants for the motion vector block mask
package mvbm_pkg;

	localparam int FI_W  = 16;
	localparam int VEC_W = 8;

	typedef enum logic [1:0] {
		FUNC_STORE  = 2'd0,
		FUNC_MASK   = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_UNUSED = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_MAP_8X8      = 3'd0,
		REG_FRAME_WIDTH  = 3'd1,
		REG_FRAME_HEIGHT = 3'd2,
		REG_THRESHOLD    = 3'd3,
		REG_FRAME_INDEX  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [VEC_W-1:0] vx;
		logic [VEC_W-1:0] vy;
	} map_word_t;

	typedef struct packed {
		logic busy;
		logic is_ref;
	} ref_stat_t;

endpackage

// ===== rtl/mvbm_map_store.sv =====
// Motion vector map memory with a clearing sweep after reset
module mvbm_map_store
	import mvbm_pkg::*;
#(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  map_word_t       wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output map_word_t       rd_data,
	output logic            clearing
);

	map_word_t       mem [DEPTH];
	map_word_t       rd_data_q;
	logic [AW-1:0]   clr_addr_q;
	logic            clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// one write port shared by the sweep and the store path, one read port
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

// ===== rtl/mvbm_ref_calc.sv =====
// Reference frame flag from the frame index by reciprocal multiplication
module mvbm_ref_calc
	import mvbm_pkg::*;
#(
	parameter int PERIOD = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [FI_W-1:0] value,
	output ref_stat_t       stat
);

	// ceil(2^32 / PERIOD) gives the exact quotient for every 16-bit index
	localparam logic [32:0] RECIP =
		33'(((64'd1 << 32) + 64'(PERIOD) - 64'd1) / 64'(PERIOD));

	typedef enum logic [1:0] {ST_IDLE, ST_QUOT, ST_CHECK} state_t;

	state_t            state_q;
	logic [FI_W-1:0]   val_q;
	logic [FI_W-1:0]   quot_q;
	logic              one_q;
	logic              is_ref_q;
	logic [FI_W-1:0]   quot;
	logic [FI_W-1:0]   back;

	always_comb begin
		quot = FI_W'((48'(val_q) * 48'(RECIP)) >> 32);
		back = quot_q * FI_W'(PERIOD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			val_q    <= '0;
			quot_q   <= '0;
			one_q    <= 1'b0;
			is_ref_q <= 1'b1;
		end else if (start) begin
			// restart on every write, the latest index wins
			val_q   <= value;
			one_q   <= (value == FI_W'(1));
			state_q <= ST_QUOT;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_QUOT: begin
					quot_q  <= quot;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					is_ref_q <= (back == val_q) || one_q;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.busy   = (state_q != ST_IDLE);
	assign stat.is_ref = is_ref_q;

endmodule

// ===== rtl/motion_vector_block_mask.sv =====
// Motion vector block mask: top level with map access, mask stage and output register
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: func 0 stores the
//   vector dest minus source in the destination macroblock, func 1 masks one RGB pixel by
//   the motion stored for its block, func 2 reads back a map entry. Every item gives
//   exactly one result on the output channel (out_valid / out_stall).
//   out_valid rises once the item has moved from the evaluation stage into the output register.
//   The map memory is read or written in the accept cycle and its registered data is
//   evaluated in the evaluation stage; with the receiver ready and no clearing sweep or
//   reference update running, items stream at one per cycle, at most one map access each.
//   Stores write in the accept cycle, so a following read sees the new entry directly.
//   When the receiver stalls, the result holds in the output register and one more item
//   waits in the evaluation stage; the receiver stalls the input only when both are occupied.
//   Reset clears the configuration to its defaults and starts a clearing sweep of the
//   map, all MAP_SIZE*MAP_SIZE entries, one entry a cycle; in_stall is high during it.
//   A write to the frame index starts a reciprocal multiply in a quotient step and a
//   check step that decides the reference frame flag; in_stall is high while it runs.
//   Other writes take effect at once. Configuration is written through cfg_write /
//   cfg_index / cfg_data while idle.
//
`include "motion_vector_block_mask_assert.svh"
module motion_vector_block_mask
	import mvbm_pkg::*;
#(
	parameter int MAP_SIZE         = 64,
	parameter int REFERENCE_PERIOD = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [9:0]         dest_x,
	input  logic [9:0]         dest_y,
	input  logic signed [13:0] source_x,
	input  logic signed [13:0] source_y,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         red_out,
	output logic [7:0]         green_out,
	output logic [7:0]         blue_out,
	output logic signed [7:0]  vector_x,
	output logic signed [7:0]  vector_y
);

	localparam int IW    = $clog2(MAP_SIZE);
	localparam int DEPTH = MAP_SIZE * MAP_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int GW    = 9;

	// blocks along one frame dimension, at least one, capped at the map size
	function automatic logic [GW-1:0] grid_dim(input logic [10:0] pix, input logic sel8);
		logic [GW-1:0] n;
		n = sel8 ? GW'(pix[10:3]) : GW'(pix[10:4]);
		if (n == '0) n = GW'(1);
		if (n > GW'(MAP_SIZE)) n = GW'(MAP_SIZE);
		return n;
	endfunction

	// configuration registers
	logic         map_8x8_q;
	logic [10:0]  frame_width_q;
	logic [10:0]  frame_height_q;
	logic [15:0]  threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_8x8_q      <= 1'b0;
			frame_width_q  <= 11'd1024;
			frame_height_q <= 11'd1024;
			threshold_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAP_8X8:      map_8x8_q      <= cfg_data[0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[10:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[10:0];
				REG_THRESHOLD:    threshold_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// reference frame flag, recomputed on every frame index write
	ref_stat_t ref_stat;

	mvbm_ref_calc #(
		.PERIOD (REFERENCE_PERIOD)
	) u_ref_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_write && (cfg_index == REG_FRAME_INDEX)),
		.value  (cfg_data),
		.stat   (ref_stat)
	);

	// accept stage: block address, range checks, map access
	logic [GW-1:0]  cols, rows;
	logic [GW-1:0]  blk_x, blk_y, clamp_x, clamp_y;
	logic           in_grid, read_ok;
	logic [IW-1:0]  col_sel, row_sel;
	logic [AW-1:0]  map_addr;
	map_word_t      new_vec;
	map_word_t      rd_data;
	logic           clearing;
	logic           accept, wr_en, rd_en;
	logic           valid_s1, s1_move;

	always_comb begin
		cols    = grid_dim(frame_width_q, map_8x8_q);
		rows    = grid_dim(frame_height_q, map_8x8_q);
		blk_x   = map_8x8_q ? GW'(dest_x[9:3]) : GW'(dest_x[9:4]);
		blk_y   = map_8x8_q ? GW'(dest_y[9:3]) : GW'(dest_y[9:4]);
		clamp_x = (blk_x > cols - GW'(1)) ? cols - GW'(1) : blk_x;
		clamp_y = (blk_y > rows - GW'(1)) ? rows - GW'(1) : blk_y;
		in_grid = (blk_x < cols) && (blk_y < rows);
		read_ok = (dest_x < 10'(MAP_SIZE)) && (dest_y < 10'(MAP_SIZE));
		unique case (func)
			FUNC_STORE: begin
				col_sel = clamp_x[IW-1:0];
				row_sel = clamp_y[IW-1:0];
			end
			FUNC_MASK: begin
				col_sel = blk_x[IW-1:0];
				row_sel = blk_y[IW-1:0];
			end
			FUNC_READ: begin
				col_sel = dest_x[IW-1:0];
				row_sel = dest_y[IW-1:0];
			end
			default: begin
				col_sel = '0;
				row_sel = '0;
			end
		endcase
		map_addr   = AW'(row_sel) * AW'(MAP_SIZE) + AW'(col_sel);
		// keep the low byte of dest minus source
		new_vec.vx = dest_x[7:0] - source_x[7:0];
		new_vec.vy = dest_y[7:0] - source_y[7:0];
	end

	// stall while clearing, while the reference flag settles, or when both stages are full
	assign in_stall = clearing || ref_stat.busy || (valid_s1 && !s1_move);
	assign accept   = in_valid && !in_stall;
	assign wr_en    = accept && (func == FUNC_STORE);
	assign rd_en    = accept && (((func == FUNC_MASK) && in_grid) ||
	                             ((func == FUNC_READ) && read_ok));

	mvbm_map_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_map_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (map_addr),
		.wr_data  (new_vec),
		.rd_en    (rd_en),
		.rd_addr  (map_addr),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	// evaluation stage: item fields wait here for the map read data
	logic [1:0]  func_s1;
	logic        hit_s1;
	logic [7:0]  red_s1, green_s1, blue_s1;
	map_word_t   vec_s1;
	logic        out_valid_q;

	assign s1_move = valid_s1 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			hit_s1   <= rd_en;
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
			vec_s1   <= new_vec;
		end
	end

	// motion test on the stored vector
	logic [7:0]   abs_x, abs_y;
	logic [15:0]  sq_len;
	logic         pass;
	map_word_t    res_vec;
	logic [7:0]   res_red, res_green, res_blue;

	always_comb begin
		abs_x  = rd_data.vx[7] ? 8'(-rd_data.vx) : rd_data.vx;
		abs_y  = rd_data.vy[7] ? 8'(-rd_data.vy) : rd_data.vy;
		sq_len = 16'(abs_x) * 16'(abs_x) + 16'(abs_y) * 16'(abs_y);
		pass   = (sq_len > threshold_q) &&
		         (ref_stat.is_ref ||
		          (16'(abs_x) > threshold_q) || (16'(abs_y) > threshold_q));
		res_vec   = '0;
		res_red   = '0;
		res_green = '0;
		res_blue  = '0;
		unique case (func_s1)
			FUNC_STORE: begin
				res_vec = vec_s1;
			end
			FUNC_MASK: begin
				if (hit_s1) begin
					res_vec = rd_data;
					if (pass) begin
						res_red   = red_s1;
						res_green = green_s1;
						res_blue  = blue_s1;
					end
				end
			end
			FUNC_READ: begin
				if (hit_s1) res_vec = rd_data;
			end
			default: ;
		endcase
	end

	// output register: holds the result until the receiver takes it
	logic [7:0]  red_q, green_q, blue_q;
	map_word_t   vec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			red_q   <= res_red;
			green_q <= res_green;
			blue_q  <= res_blue;
			vec_q   <= res_vec;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign vector_x  = $signed(vec_q.vx);
	assign vector_y  = $signed(vec_q.vy);

	// the map sweep owns the memory ports
	`MVBM_NEVER(a_no_accept_clear, accept && clearing, "input transfer during map clear")
	// a stale reference flag would mask pixels wrongly
	`MVBM_NEVER(a_ref_busy_stall, ref_stat.busy && !in_stall, "input open while ref flag busy")
	// every accepted item must reach the evaluation stage
	`MVBM_ASSERT(a_accept_fills_s1, accept |=> valid_s1, "accepted item lost before eval stage")
	// a waiting item needs its read data untouched
	`MVBM_ASSERT(a_rd_data_held, (valid_s1 && hit_s1 && !s1_move) |=> $stable(rd_data),
		"map read data changed under a waiting item")

endmodule
